// ===== src/spsu_pkg.sv =====
// ----------------------------------------------------------------------------
// spsu_pkg
// shared types and codes of the stepper position sequencer
// ----------------------------------------------------------------------------
package spsu_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned BASE_W   = 10;
  localparam int unsigned STATE_W  = 3;
  localparam int unsigned POS_OUT_W = 16;
  localparam int unsigned IN_W     = 24;
  localparam int unsigned OUT_W    = 64;

  localparam logic [BASE_W-1:0] BASE_RESET = 10'd10;

  // item kinds carried in tuser
  localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GOTO  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WAIT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DELAY = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CAL   = 3'd4;

  // controller states, also reported as ctrl_state
  localparam logic [STATE_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [STATE_W-1:0] ST_MOVING = 3'd1;
  localparam logic [STATE_W-1:0] ST_DELAY  = 3'd2;
  localparam logic [STATE_W-1:0] ST_WAIT   = 3'd3;
  localparam logic [STATE_W-1:0] ST_HOMING = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic tick;
    logic push;
    logic dropped;
    logic detector;
  } front_req_t;

  typedef struct packed {
    logic [STATE_W-1:0]   state;
    logic [POS_OUT_W-1:0] pos;
    logic [POS_OUT_W-1:0] tgt;
    logic [VALUE_W-1:0]   delay;
    logic                 step_right;
    logic                 step_left;
  } ctrl_status_t;

endpackage

// ===== src/spsu_front.sv =====
// ----------------------------------------------------------------------------
// spsu_front
// classifies accepted items into ticks, queued commands and commands dropped on a full queue
// ----------------------------------------------------------------------------
module spsu_front (
  input  logic                          fire_i,
  input  logic [spsu_pkg::MODE_W-1:0]   mode_i,
  input  logic [spsu_pkg::VALUE_W-1:0]  value_i,
  input  logic                          detector_i,
  input  logic                          fifo_full_i,
  output spsu_pkg::front_req_t          req_o,
  output spsu_pkg::cmd_t                cmd_o
);
  import spsu_pkg::*;

  logic is_cmd;

  always_comb begin
    is_cmd       = mode_i inside {[MODE_GOTO:MODE_CAL]};
    req_o.tick     = fire_i && (mode_i == MODE_TICK);
    req_o.push     = fire_i && is_cmd && !fifo_full_i;
    req_o.dropped  = fire_i && is_cmd && fifo_full_i;
    req_o.detector = detector_i;
    cmd_o.mode     = mode_i;
    cmd_o.value    = value_i;
  end

endmodule

// ===== src/spsu_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// spsu_cmd_fifo
// command queue with a prefetched head entry
// ----------------------------------------------------------------------------
module spsu_cmd_fifo #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned CW    = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  spsu_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output spsu_pkg::cmd_t head_o,
  output logic [CW-1:0]  count_o,
  output logic           full_o
);
  import spsu_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  cmd_t          mem [DEPTH];
  cmd_t          head_q;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [CW-1:0] count_q, count_d;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
      count_d  = count_d - 1'b1;
    end
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
      count_d  = count_d + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  // head register tracks the entry at the read pointer, bypassing a same-slot write
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= cmd_i;
    end
    if (push_i && (wr_ptr_q == rd_ptr_d)) begin
      head_q <= cmd_i;
    end else begin
      head_q <= mem[rd_ptr_d];
    end
  end

  assign head_o  = head_q;
  assign count_o = count_q;
  assign full_o  = (count_q == CW'(DEPTH));

endmodule

// ===== src/spsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// spsu_ctrl
// motion controller: tick countdown, command execution and homing
// ----------------------------------------------------------------------------
module spsu_ctrl #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_i,
  input  logic                          detector_i,
  input  logic [spsu_pkg::BASE_W-1:0]   base_i,
  input  logic                          fifo_nonempty_i,
  input  spsu_pkg::cmd_t                head_i,
  output logic                          pop_o,
  output spsu_pkg::ctrl_status_t        status_o
);
  import spsu_pkg::*;

  localparam int unsigned CD_W = 17;

  logic [STATE_W-1:0]       state_q, state_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d, tgt_q, tgt_d;
  logic [VALUE_W-1:0]       delay_q, delay_d, wait_q, wait_d;
  logic [CD_W-1:0]          cd_q, cd_d;
  logic [VALUE_W-1:0]       extra;
  logic [BASE_W-1:0]        base_m1;
  logic                     right, left;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    tgt_d   = tgt_q;
    delay_d = delay_q;
    wait_d  = wait_q;
    cd_d    = cd_q;
    extra   = '0;
    right   = 1'b0;
    left    = 1'b0;
    pop_o   = 1'b0;
    // a zero base period acts as one
    base_m1 = (base_i == '0) ? '0 : base_i - 1'b1;
    if (tick_i) begin
      if (cd_q != '0) begin
        cd_d = cd_q - 1'b1;
      end else begin
        case (state_q)
          ST_MOVING: begin
            if (pos_q < tgt_q) begin
              right   = 1'b1;
              pos_d   = pos_q + 1'b1;
              state_d = ST_DELAY;
            end else if (pos_q > tgt_q) begin
              left    = 1'b1;
              pos_d   = pos_q - 1'b1;
              state_d = ST_DELAY;
            end else begin
              state_d = ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (fifo_nonempty_i) begin
              pop_o = 1'b1;
              case (head_i.mode)
                MODE_GOTO: begin
                  tgt_d   = POSITION_BITS'(head_i.value);
                  state_d = ST_MOVING;
                end
                MODE_WAIT: begin
                  wait_d  = head_i.value;
                  state_d = ST_WAIT;
                end
                MODE_DELAY: begin
                  delay_d = head_i.value;
                  state_d = ST_DELAY;
                end
                default: begin
                  state_d = ST_HOMING;
                end
              endcase
            end
          end
          ST_WAIT: begin
            extra   = wait_q;
            state_d = ST_IDLE;
          end
          ST_DELAY: begin
            extra   = delay_q;
            state_d = ST_MOVING;
          end
          default: begin
            // homing: detector pin is active low
            if (!detector_i) begin
              state_d = ST_IDLE;
              pos_d   = '0;
              tgt_d   = '0;
              delay_d = '0;
            end else begin
              left = 1'b1;
            end
          end
        endcase
        cd_d = CD_W'(extra) + CD_W'(base_m1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HOMING;
      pos_q   <= '0;
      tgt_q   <= '0;
      delay_q <= '0;
      wait_q  <= '0;
      cd_q    <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      tgt_q   <= tgt_d;
      delay_q <= delay_d;
      wait_q  <= wait_d;
      cd_q    <= cd_d;
    end
  end

  always_comb begin
    status_o.state      = state_d;
    status_o.pos        = POS_OUT_W'(pos_d);
    status_o.tgt        = POS_OUT_W'(tgt_d);
    status_o.delay      = delay_d;
    status_o.step_right = right;
    status_o.step_left  = left;
  end

endmodule

// ===== src/spsu_out_buf.sv =====
// ----------------------------------------------------------------------------
// spsu_out_buf
// two-entry result buffer: output register plus skid stage
// ----------------------------------------------------------------------------
module spsu_out_buf #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic [W-1:0] in_data_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  output logic [W-1:0] out_data_o,
  input  logic         out_ready_i
);
  import spsu_pkg::*;

  logic         out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic [W-1:0] out_data_q, skid_data_q;
  logic         in_fire, out_take, load_out_in, load_out_skid, load_skid;

  always_comb begin
    in_fire       = in_valid_i && !skid_valid_q;
    out_take      = out_valid_q && out_ready_i;
    out_valid_d   = out_valid_q && !out_take;
    skid_valid_d  = skid_valid_q;
    load_out_skid = 1'b0;
    load_out_in   = 1'b0;
    load_skid     = 1'b0;
    if (skid_valid_q && out_take) begin
      load_out_skid = 1'b1;
      out_valid_d   = 1'b1;
      skid_valid_d  = 1'b0;
    end
    if (in_fire) begin
      if (!out_valid_d) begin
        load_out_in = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_in) begin
      out_data_q <= in_data_i;
    end else if (load_out_skid) begin
      out_data_q <= skid_data_q;
    end
    if (load_skid) begin
      skid_data_q <= in_data_i;
    end
  end

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== src/stepper_position_sequencer_unit.sv =====
// output: each result is registered in the output register, or in the skid stage while that is held
// throughput: one request per cycle while the skid stage is empty, set by the controller update
// and the one-entry-per-cycle command queue memory
// reset: controller homing, queue empty, base period 10; queue memory is not cleared
// ----------------------------------------------------------------------------
// stepper_position_sequencer_unit
// stepper position sequencer with command queue and homing
// ----------------------------------------------------------------------------
module stepper_position_sequencer_unit #(
  parameter int unsigned FIFO_DEPTH    = 128,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spsu_pkg::BASE_W-1:0]     cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // value[15:0], detector_pin[16], zero fill
  input  logic [spsu_pkg::IN_W-1:0]       s_axis_tdata,
  // mode[2:0]
  input  logic [spsu_pkg::MODE_W-1:0]     s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // ctrl_state[2:0], position_now[18:3], position_target[34:19],
  // step_delay_now[50:35], step_right[51], step_left[52],
  // command_dropped[53], queued_count[61:54], zero fill
  output logic [spsu_pkg::OUT_W-1:0]      m_axis_tdata
);
  import spsu_pkg::*;

  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  logic [BASE_W-1:0] base_q;
  logic              s_fire;
  front_req_t        req;
  cmd_t              cmd, head;
  logic              pop, fifo_full;
  logic [CW-1:0]     fifo_count;
  logic [CW-1:0]     count_after;
  logic [7:0]        queued;
  ctrl_status_t      status;
  logic [OUT_W-1:0]  result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  assign s_fire = s_axis_tvalid && s_axis_tready;

  spsu_front u_front (
    .fire_i      (s_fire),
    .mode_i      (s_axis_tuser),
    .value_i     (s_axis_tdata[VALUE_W-1:0]),
    .detector_i  (s_axis_tdata[VALUE_W]),
    .fifo_full_i (fifo_full),
    .req_o       (req),
    .cmd_o       (cmd)
  );

  spsu_cmd_fifo #(
    .DEPTH (FIFO_DEPTH),
    .CW    (CW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (req.push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (fifo_count),
    .full_o  (fifo_full)
  );

  spsu_ctrl #(
    .POSITION_BITS (POSITION_BITS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tick_i          (req.tick),
    .detector_i      (req.detector),
    .base_i          (base_q),
    .fifo_nonempty_i (fifo_count != '0),
    .head_i          (head),
    .pop_o           (pop),
    .status_o        (status)
  );

  always_comb begin
    count_after = fifo_count;
    if (req.push) begin
      count_after = fifo_count + 1'b1;
    end else if (pop) begin
      count_after = fifo_count - 1'b1;
    end
    queued = (32'(count_after) > 32'd255) ? 8'hFF : 8'(count_after);
    result = {2'b00, queued, req.dropped, status.step_left, status.step_right,
              status.delay, status.tgt, status.pos, status.state};
  end

  spsu_out_buf #(
    .W (OUT_W)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_data_i   (result),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_ready_i (m_axis_tready)
  );

`ifndef SYNTHESIS
  a_no_dual_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[51] && m_axis_tdata[52]))
    else $error("both step directions in one result");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fifo_count) <= FIFO_DEPTH)
    else $error("command queue count beyond depth");

  a_push_pop_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req.push && pop))
    else $error("push and pop on the same request");

  a_drop_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.dropped |-> (fifo_full && !pop))
    else $error("command dropped while queue had room");
`endif

endmodule

// ===== tb/stepper_position_sequencer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// stepper_position_sequencer_unit_tb
// checks the stepper sequencer: a behavioral predictor follows every accepted
// tick or command, and each status word from the block is compared with it
// ----------------------------------------------------------------------------
module stepper_position_sequencer_unit_tb;
  import spsu_pkg::*;

  localparam int unsigned QDEPTH      = 128;
  localparam int unsigned POS_BITS    = 16;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned GAP_MAX     = 19;

  typedef enum logic [STATE_W-1:0] {
    CTL_IDLE   = ST_IDLE,
    CTL_MOVING = ST_MOVING,
    CTL_DELAY  = ST_DELAY,
    CTL_WAIT   = ST_WAIT,
    CTL_HOMING = ST_HOMING
  } ctl_state_e;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
    logic               detector;
    int unsigned        gap;
  } motor_req_t;

  typedef struct packed {
    logic [STATE_W-1:0]   state;
    logic [POS_OUT_W-1:0] pos;
    logic [POS_OUT_W-1:0] tgt;
    logic [VALUE_W-1:0]   delay;
    logic                 step_right;
    logic                 step_left;
    logic                 dropped;
    logic [7:0]           count;
  } motor_status_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [BASE_W-1:0]   cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata  = '0;
  logic [MODE_W-1:0]   s_axis_tuser  = MODE_TICK;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;

  stepper_position_sequencer_unit #(
    .FIFO_DEPTH   (QDEPTH),
    .POSITION_BITS(POS_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  ctl_state_e          motor_state = CTL_HOMING;
  logic [POS_BITS-1:0] pos_now     = '0;
  logic [POS_BITS-1:0] pos_goal    = '0;
  logic [VALUE_W-1:0]  step_gap    = '0;
  logic [VALUE_W-1:0]  pause_len   = '0;
  logic [16:0]         tick_left   = '0;
  logic [BASE_W-1:0]   base_ticks  = BASE_RESET;
  cmd_t                cmd_store[QDEPTH];
  int unsigned         cmd_head    = 0;
  int unsigned         cmd_count   = 0;

  motor_req_t    request_q[$];
  motor_status_t expected_status_q[$];
  motor_req_t    cur_req;
  bit            req_loaded = 1'b0;
  bit            req_shown  = 1'b0;
  bit            req_fire   = 1'b0;
  bit            status_taken = 1'b0;
  int unsigned   sink_wait    = 0;
  int unsigned   sink_stall_max = GAP_MAX;
  int unsigned   hold_cycles  = 0;
  int unsigned   err_count    = 0;
  int unsigned   cycle_count  = 0;

  function automatic motor_status_t advance_motor(input motor_req_t req);
    motor_status_t r;
    cmd_t          c;
    logic [16:0]   extra;
    r = '0;
    if (req.mode == MODE_TICK) begin
      if (tick_left != 0) begin
        tick_left = tick_left - 17'd1;
      end else begin
        extra = '0;
        case (motor_state)
          CTL_MOVING: begin
            if (pos_now < pos_goal) begin
              r.step_right = 1'b1;
              pos_now      = pos_now + 1'b1;
              motor_state  = CTL_DELAY;
            end else if (pos_now > pos_goal) begin
              r.step_left = 1'b1;
              pos_now     = pos_now - 1'b1;
              motor_state = CTL_DELAY;
            end else begin
              motor_state = CTL_IDLE;
            end
          end
          CTL_IDLE: begin
            if (cmd_count != 0) begin
              c         = cmd_store[cmd_head];
              cmd_head  = (cmd_head + 1) % QDEPTH;
              cmd_count = cmd_count - 1;
              case (c.mode)
                MODE_GOTO: begin
                  pos_goal    = c.value[POS_BITS-1:0];
                  motor_state = CTL_MOVING;
                end
                MODE_WAIT: begin
                  pause_len   = c.value;
                  motor_state = CTL_WAIT;
                end
                MODE_DELAY: begin
                  // speed change also resumes motion toward the held target
                  step_gap    = c.value;
                  motor_state = CTL_DELAY;
                end
                default: motor_state = CTL_HOMING;
              endcase
            end
          end
          CTL_WAIT: begin
            extra       = 17'(pause_len);
            motor_state = CTL_IDLE;
          end
          CTL_DELAY: begin
            extra       = 17'(step_gap);
            motor_state = CTL_MOVING;
          end
          default: begin
            // detector is active low; homing pulses left without moving position
            if (!req.detector) begin
              motor_state = CTL_IDLE;
              pos_now     = '0;
              pos_goal    = '0;
              step_gap    = '0;
            end else begin
              r.step_left = 1'b1;
            end
          end
        endcase
        // a zero base period behaves like one
        tick_left = extra + ((base_ticks == 0) ? 17'd0 : 17'(base_ticks) - 17'd1);
      end
    end else if (req.mode <= MODE_CAL) begin
      if (cmd_count < QDEPTH) begin
        cmd_store[(cmd_head + cmd_count) % QDEPTH] = '{mode: req.mode, value: req.value};
        cmd_count = cmd_count + 1;
      end else begin
        r.dropped = 1'b1;
      end
    end
    r.state = motor_state;
    r.pos   = pos_now;
    r.tgt   = pos_goal;
    r.delay = step_gap;
    r.count = (cmd_count > 255) ? 8'd255 : 8'(cmd_count);
    return r;
  endfunction

  function automatic bit field_ok(input string name, input longint unsigned want,
                                  input longint unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // monitor: samples both handshakes and checks each status word
  always @(posedge clk_i) begin
    motor_status_t want;
    motor_status_t got;
    bit            ok;
    req_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      status_taken = 1'b1;
      got.state      = m_axis_tdata[2:0];
      got.pos        = m_axis_tdata[18:3];
      got.tgt        = m_axis_tdata[34:19];
      got.delay      = m_axis_tdata[50:35];
      got.step_right = m_axis_tdata[51];
      got.step_left  = m_axis_tdata[52];
      got.dropped    = m_axis_tdata[53];
      got.count      = m_axis_tdata[61:54];
      if (expected_status_q.size() == 0) begin
        $error("status word with no request outstanding: %h", m_axis_tdata);
        err_count++;
      end else begin
        want = expected_status_q.pop_front();
        ok = 1'b1;
        ok &= field_ok("ctrl_state", want.state, got.state);
        ok &= field_ok("position_now", want.pos, got.pos);
        ok &= field_ok("position_target", want.tgt, got.tgt);
        ok &= field_ok("step_delay_now", want.delay, got.delay);
        ok &= field_ok("step_right", want.step_right, got.step_right);
        ok &= field_ok("step_left", want.step_left, got.step_left);
        ok &= field_ok("command_dropped", want.dropped, got.dropped);
        ok &= field_ok("queued_count", want.count, got.count);
        if (!ok) err_count++;
      end
    end
  end

  // driver: predicts each accepted request, then presents the next one
  always @(negedge clk_i) begin
    if (req_fire) begin
      expected_status_q.push_back(advance_motor(cur_req));
      req_loaded = 1'b0;
      req_shown  = 1'b0;
    end
    if (!req_loaded && request_q.size() != 0) begin
      cur_req    = request_q.pop_front();
      req_loaded = 1'b1;
    end
    if (req_loaded && !req_shown) begin
      if (cur_req.gap != 0) cur_req.gap = cur_req.gap - 1;
      else req_shown = 1'b1;
    end
    s_axis_tvalid <= req_shown;
    s_axis_tdata  <= IN_W'({cur_req.detector, cur_req.value});
    s_axis_tuser  <= cur_req.mode;
  end

  // receiver: random stall after each status word, plus an optional long hold
  always @(negedge clk_i) begin
    if (status_taken) begin
      status_taken = 1'b0;
      sink_wait    = $urandom_range(0, sink_stall_max);
    end
    if (hold_cycles != 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else if (sink_wait != 0) begin
      sink_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("stepper_position_sequencer_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic post_request(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value,
                              input logic detector, input int unsigned gap);
    motor_req_t r;
    r.mode     = mode;
    r.value    = value;
    r.detector = detector;
    r.gap      = gap;
    request_q.push_back(r);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (request_q.size() != 0 || req_loaded || expected_status_q.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic load_base_period(input logic [BASE_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    base_ticks  = v;
    @(posedge clk_i);
  endtask

  function automatic motor_req_t random_request(input int unsigned gap_max);
    motor_req_t  r;
    int unsigned roll;
    roll       = $urandom_range(0, 99);
    r.value    = 16'($urandom);
    r.detector = ($urandom_range(0, 3) != 0);
    r.gap      = $urandom_range(0, gap_max);
    if (roll < 80) begin
      r.mode = MODE_TICK;
    end else if (roll < 87) begin
      r.mode  = MODE_GOTO;
      r.value = 16'($urandom_range(0, 8));
    end else if (roll < 91) begin
      r.mode  = MODE_DELAY;
      r.value = 16'($urandom_range(0, 3));
    end else if (roll < 95) begin
      r.mode  = MODE_WAIT;
      r.value = 16'($urandom_range(0, 6));
    end else if (roll < 98) begin
      r.mode = MODE_CAL;
    end else begin
      r.mode = MODE_W'($urandom_range(int'(MODE_CAL) + 1, (1 << MODE_W) - 1));
    end
    return r;
  endfunction

  task automatic run_phase(input int unsigned n, input logic [BASE_W-1:0] base,
                           input int unsigned stall_max);
    int unsigned gap_max;
    gap_max = GAP_MAX;
    load_base_period(base);
    sink_stall_max = stall_max;
    for (int unsigned i = 0; i < n; i++) begin
      // stretches without sender gaps now and then
      if (i % 40 == 0) gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      request_q.push_back(random_request(gap_max));
    end
    wait_idle();
  endtask

  // bring the controller to idle with an empty queue and no countdown pending
  task automatic settle();
    load_base_period(10'd1);
    while (!(motor_state == CTL_IDLE && cmd_count == 0 && tick_left == 0)) begin
      repeat (32) post_request(MODE_TICK, '0, 1'b0, 0);
      wait_idle();
    end
  endtask

  initial begin
    logic [MODE_W-1:0] m;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // homing out of reset at the reset base period of ten ticks
    post_request(MODE_TICK, 16'hFFFF, 1'b1, $urandom_range(0, GAP_MAX));
    repeat (9) post_request(MODE_TICK, 16'($urandom), 1'b1, $urandom_range(0, GAP_MAX));
    post_request(MODE_TICK, '0, 1'b0, $urandom_range(0, GAP_MAX));
    wait_idle();

    // zero base period, each command kind and the ignored modes
    load_base_period(10'd0);
    post_request(MODE_GOTO, 16'd2, 1'b1, $urandom_range(0, GAP_MAX));
    post_request(MODE_DELAY, 16'd1, 1'b0, $urandom_range(0, GAP_MAX));
    post_request(MODE_WAIT, 16'd1, 1'b1, $urandom_range(0, GAP_MAX));
    m = MODE_CAL + 3'd1;
    post_request(m, 16'hFFFF, 1'b1, $urandom_range(0, GAP_MAX));
    m = '1;
    post_request(m, '0, 1'b0, $urandom_range(0, GAP_MAX));
    post_request(MODE_CAL, 16'h8000, 1'b1, $urandom_range(0, GAP_MAX));
    repeat (14) post_request(MODE_TICK, '0, 1'b1, $urandom_range(0, GAP_MAX));
    post_request(MODE_TICK, '0, 1'b0, $urandom_range(0, GAP_MAX));
    wait_idle();

    run_phase(250, 10'd1, GAP_MAX);
    run_phase(200, 10'd2, 0);

    // fill the command queue past full while the receiver holds off
    settle();
    sink_stall_max = GAP_MAX;
    hold_cycles    = 300;
    for (int unsigned i = 0; i < QDEPTH; i++) begin
      case ($urandom_range(0, 3))
        0: post_request(MODE_GOTO, 16'($urandom_range(0, 4)), 1'b1, 0);
        1: post_request(MODE_WAIT, 16'($urandom_range(0, 2)), 1'b1, 0);
        2: post_request(MODE_DELAY, 16'($urandom_range(0, 1)), 1'b1, 0);
        default: post_request(MODE_CAL, 16'($urandom), 1'b1, 0);
      endcase
    end
    // these land on a full queue and are dropped, so any value is safe
    post_request(MODE_GOTO, 16'hFFFF, 1'b0, 0);
    post_request(MODE_WAIT, 16'hFFFF, 1'b1, 0);
    post_request(MODE_DELAY, 16'hFFFF, 1'b0, 0);
    post_request(MODE_CAL, '0, 1'b1, 0);
    repeat (3) post_request(MODE_W'($urandom_range(int'(MODE_GOTO), int'(MODE_CAL))),
                            16'($urandom), 1'b1, $urandom_range(0, GAP_MAX));
    wait_idle();
    settle();

    run_phase(150, 10'd3, GAP_MAX);
    run_phase(100, 10'd1000, GAP_MAX);
    run_phase(150, 10'd0, GAP_MAX);

    // long countdown: a wait stacked on a larger base period
    settle();
    load_base_period(10'd40);
    sink_stall_max = 0;
    post_request(MODE_WAIT, 16'd150, 1'b1, 0);
    repeat (240) post_request(MODE_TICK, 16'($urandom), 1'($urandom_range(0, 1)), 0);
    wait_idle();

    repeat (4) @(posedge clk_i);
    if (err_count == 0) begin
      $display("stepper_position_sequencer_unit_tb: done, clean");
    end else begin
      $display("stepper_position_sequencer_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/spsu_pkg.sv
src/spsu_front.sv
src/spsu_cmd_fifo.sv
src/spsu_ctrl.sv
src/spsu_out_buf.sv
src/stepper_position_sequencer_unit.sv
tb/stepper_position_sequencer_unit_tb.sv
